// ===== src/lra_pkg.sv =====
// shared constants and types for the largest remainder apportionment core
package lra_pkg;

  localparam int BUCKET_COUNT = 5;
  localparam int IN_W         = 16;
  localparam int TOT_W        = 15;
  localparam int SUM_W        = TOT_W + $clog2(BUCKET_COUNT);
  localparam int PROD_W       = 2 * TOT_W;
  localparam int DIV_STEPS    = TOT_W;
  localparam int FB_W         = 3;
  localparam int LEFT_W       = $clog2(BUCKET_COUNT);

  typedef logic [TOT_W-1:0] share_t;

  // one divider stage: partial remainders and shifting dividend/quotient words
  typedef struct packed {
    logic                                vld;
    logic [BUCKET_COUNT-1:0][SUM_W-1:0]  rem;
    logic [BUCKET_COUNT-1:0][TOT_W-1:0]  pq;
    logic [TOT_W-1:0]                    total;
    logic [SUM_W-1:0]                    sum;
    logic                                pos;
    logic [FB_W-1:0]                     fb;
  } div_stage_t;

  function automatic share_t clamp_weight(input logic signed [IN_W-1:0] w);
    clamp_weight = w[IN_W-1] ? '0 : w[TOT_W-1:0];
  endfunction

endpackage

// ===== src/lra_if.sv =====
// channel interfaces: item in, shares out, fallback register write
interface lra_in_if;
  import lra_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] total_count;
  logic signed [IN_W-1:0] weight_0;
  logic signed [IN_W-1:0] weight_1;
  logic signed [IN_W-1:0] weight_2;
  logic signed [IN_W-1:0] weight_3;
  logic signed [IN_W-1:0] weight_4;
  modport source (output valid, total_count, weight_0, weight_1, weight_2, weight_3,
                  weight_4, input ready);
  modport sink   (input valid, total_count, weight_0, weight_1, weight_2, weight_3,
                  weight_4, output ready);
endinterface

interface lra_out_if;
  import lra_pkg::*;
  logic             valid;
  logic             ready;
  logic [TOT_W-1:0] share_0;
  logic [TOT_W-1:0] share_1;
  logic [TOT_W-1:0] share_2;
  logic [TOT_W-1:0] share_3;
  logic [TOT_W-1:0] share_4;
  modport source (output valid, share_0, share_1, share_2, share_3, share_4, input ready);
  modport sink   (input valid, share_0, share_1, share_2, share_3, share_4, output ready);
endinterface

interface lra_cfg_if;
  import lra_pkg::*;
  logic            valid;
  logic            ready;
  logic [FB_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/largest_remainder_apportion_core.sv =====
// top level: pipelined largest remainder apportionment over five buckets
//
//  channel  direction  payload                             transaction when
//  in_ch    sink       total_count, weight_0..weight_4     valid && ready
//  out_ch   source     share_0..share_4                    valid && ready
//  cfg_ch   sink       data (fallback bucket)              valid && ready
//
// one item per cycle unless the output stalls; a result passes in order through
// (capture, multiply, 15 restoring divider stages, ranking, output register)
// the divider takes one quotient bit per stage for all buckets at once
// a stalled output freezes every stage together, in_ch.ready follows it
// rst_n clears the valid bits and sets the fallback bucket to 3
module largest_remainder_apportion_core
  import lra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lra_in_if.sink    in_ch,
  lra_out_if.source out_ch,
  lra_cfg_if.sink   cfg_ch
);

  logic en;
  logic [FB_W-1:0] fallback_r;

  // capture stage
  logic                               s0_vld_r;
  logic [TOT_W-1:0]                   s0_total_r;
  logic                               s0_pos_r;
  logic [BUCKET_COUNT-1:0][TOT_W-1:0] s0_w_r;
  logic [FB_W-1:0]                    s0_fb_r;
  logic [BUCKET_COUNT-1:0][TOT_W-1:0] in_w;

  // multiply stage
  logic                                s1_vld_r;
  logic [BUCKET_COUNT-1:0][PROD_W-1:0] s1_p_r;
  logic [SUM_W-1:0]                    s1_sum_r;
  logic [TOT_W-1:0]                    s1_total_r;
  logic                                s1_pos_r;
  logic [FB_W-1:0]                     s1_fb_r;
  logic [SUM_W-1:0]                    sum_nxt;

  div_stage_t dv_r   [DIV_STEPS];
  div_stage_t dv_nxt [DIV_STEPS];
  div_stage_t dv_init;

  // ranking stage
  logic                                    rk_vld_r;
  logic [BUCKET_COUNT-1:0][TOT_W-1:0]      rk_q_r;
  logic [BUCKET_COUNT-1:0][BUCKET_COUNT-1:0] rk_beat_r;
  logic [LEFT_W-1:0]                       rk_left_r;
  logic [TOT_W-1:0]                        rk_total_r;
  logic                                    rk_pos_r;
  logic                                    rk_zero_r;
  logic [FB_W-1:0]                         rk_fb_r;
  logic [BUCKET_COUNT-1:0][BUCKET_COUNT-1:0] beat_nxt;
  logic [LEFT_W-1:0]                       left_nxt;

  logic                 out_vld_r;
  share_t               share_r   [BUCKET_COUNT];
  share_t               share_nxt [BUCKET_COUNT];

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r <= FB_W'(3);
    end else if (cfg_ch.valid) begin
      fallback_r <= cfg_ch.data;
    end
  end

  assign in_w[0] = clamp_weight(in_ch.weight_0);
  assign in_w[1] = clamp_weight(in_ch.weight_1);
  assign in_w[2] = clamp_weight(in_ch.weight_2);
  assign in_w[3] = clamp_weight(in_ch.weight_3);
  assign in_w[4] = clamp_weight(in_ch.weight_4);

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < BUCKET_COUNT; i++) begin
      sum_nxt = sum_nxt + SUM_W'(s0_w_r[i]);
    end
  end

  // divider setup: the quotient fits in TOT_W bits, so the top half is below sum
  always_comb begin
    dv_init.vld   = s1_vld_r;
    dv_init.total = s1_total_r;
    dv_init.sum   = s1_sum_r;
    dv_init.pos   = s1_pos_r;
    dv_init.fb    = s1_fb_r;
    for (int i = 0; i < BUCKET_COUNT; i++) begin
      dv_init.rem[i] = SUM_W'(s1_p_r[i][PROD_W-1:TOT_W]);
      dv_init.pq[i]  = s1_p_r[i][TOT_W-1:0];
    end
  end

  always_comb begin
    logic [SUM_W:0] trial;
    logic           ge;
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_nxt[k] = (k == 0) ? dv_init : dv_r[(k == 0) ? 0 : k - 1];
      for (int i = 0; i < BUCKET_COUNT; i++) begin
        trial = {dv_nxt[k].rem[i], dv_nxt[k].pq[i][TOT_W-1]};
        ge    = trial >= {1'b0, dv_nxt[k].sum};
        dv_nxt[k].rem[i] = ge ? SUM_W'(trial - {1'b0, dv_nxt[k].sum}) : trial[SUM_W-1:0];
        dv_nxt[k].pq[i]  = {dv_nxt[k].pq[i][TOT_W-2:0], ge};
      end
    end
  end

  // pairwise remainder order, ties to the lower index, and leftover units
  always_comb begin
    logic [SUM_W-1:0] given;
    logic [SUM_W-1:0] diff;
    given = '0;
    for (int i = 0; i < BUCKET_COUNT; i++) begin
      given = given + SUM_W'(dv_r[DIV_STEPS-1].pq[i]);
      for (int j = 0; j < BUCKET_COUNT; j++) begin
        beat_nxt[i][j] = (dv_r[DIV_STEPS-1].rem[j] > dv_r[DIV_STEPS-1].rem[i]) ||
                         ((dv_r[DIV_STEPS-1].rem[j] == dv_r[DIV_STEPS-1].rem[i]) &&
                          (j < i));
      end
    end
    diff     = SUM_W'(dv_r[DIV_STEPS-1].total) - given;
    left_nxt = diff[LEFT_W-1:0];
  end

  always_comb begin
    logic [LEFT_W-1:0] rank;
    for (int i = 0; i < BUCKET_COUNT; i++) begin
      rank = LEFT_W'($countones(rk_beat_r[i]));
      if (!rk_pos_r) begin
        share_nxt[i] = '0;
      end else if (rk_zero_r) begin
        share_nxt[i] = (rk_fb_r == FB_W'(i)) ? rk_total_r : '0;
      end else begin
        share_nxt[i] = rk_q_r[i] + TOT_W'(rank < rk_left_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      rk_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r  <= in_ch.valid;
      s1_vld_r  <= s0_vld_r;
      rk_vld_r  <= dv_r[DIV_STEPS-1].vld;
      out_vld_r <= rk_vld_r;
    end
  end

  // divider stages: valid bit cleared by reset, whole stage moves on enable
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (!rst_n) begin
        dv_r[k].vld <= 1'b0;
      end else if (en) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_total_r <= in_ch.total_count[TOT_W-1:0];
      s0_pos_r   <= !in_ch.total_count[IN_W-1] && (in_ch.total_count != '0);
      s0_w_r     <= in_w;
      s0_fb_r    <= fallback_r;

      for (int i = 0; i < BUCKET_COUNT; i++) begin
        s1_p_r[i] <= PROD_W'(s0_total_r) * PROD_W'(s0_w_r[i]);
      end
      s1_sum_r   <= sum_nxt;
      s1_total_r <= s0_total_r;
      s1_pos_r   <= s0_pos_r;
      s1_fb_r    <= s0_fb_r;

      rk_q_r     <= dv_r[DIV_STEPS-1].pq;
      rk_beat_r  <= beat_nxt;
      rk_left_r  <= left_nxt;
      rk_total_r <= dv_r[DIV_STEPS-1].total;
      rk_pos_r   <= dv_r[DIV_STEPS-1].pos;
      rk_zero_r  <= (dv_r[DIV_STEPS-1].sum == '0);
      rk_fb_r    <= dv_r[DIV_STEPS-1].fb;

      for (int i = 0; i < BUCKET_COUNT; i++) begin
        share_r[i] <= share_nxt[i];
      end
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.share_0 = share_r[0];
  assign out_ch.share_1 = share_r[1];
  assign out_ch.share_2 = share_r[2];
  assign out_ch.share_3 = share_r[3];
  assign out_ch.share_4 = share_r[4];

endmodule
